### rtl/vgac_pkg.sv
// Package for the genotype alternate-allele counter.
// Holds field types, character codes and the sample limit; no dependencies.
package vgac_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [16:0] field_num_t;
	typedef logic [15:0] sample_idx_t;
	typedef logic [7:0]  count_t;

	localparam byte_t CHAR_TAB   = 8'h09;
	localparam byte_t CHAR_ONE   = 8'h31;
	localparam byte_t CHAR_COLON = 8'h3A;
	localparam byte_t CHAR_DOT   = 8'h2E;

	localparam int unsigned MAX_SAMPLES = 65536;
	localparam int unsigned INDEX_LIMIT = 65536;
	localparam int unsigned SKIP_FIELDS = 9;

	localparam field_num_t SKIP_FIELD_NUM = field_num_t'(SKIP_FIELDS);
	localparam field_num_t FIELD_NUM_MAX  = '1;
	localparam field_num_t SAMPLE_LIMIT   = field_num_t'(
		(MAX_SAMPLES < INDEX_LIMIT) ? MAX_SAMPLES : INDEX_LIMIT);

	localparam count_t COUNT_MAX         = '1;
	localparam count_t MISSING_RESET     = 8'd3;
	localparam field_num_t SAMPLES_RESET = 17'd1;

	// configuration register indexes
	localparam logic REG_MISS_CODE   = 1'b0;
	localparam logic REG_NUM_SAMPLES = 1'b1;

	typedef logic [16:0] cfg_data_t;

endpackage

### rtl/vgac_in_if.sv
// Input channel of the genotype counter: one record byte per item.
// Depends on vgac_pkg.
interface vgac_in_if;
	import vgac_pkg::*;

	logic  valid;
	logic  ready;
	byte_t char_byte;
	logic  line_end;

	modport source (output valid, char_byte, line_end, input ready);
	modport sink (input valid, char_byte, line_end, output ready);

endinterface

### rtl/vgac_out_if.sv
// Result channel of the genotype counter: sample index, count, line-end mark.
// Depends on vgac_pkg.
interface vgac_out_if;
	import vgac_pkg::*;

	logic        valid;
	logic        ready;
	sample_idx_t sample_index;
	count_t      alt_count;
	logic        last_of_line;

	modport source (output valid, sample_index, alt_count, last_of_line, input ready);
	modport sink (input valid, sample_index, alt_count, last_of_line, output ready);

endinterface

### rtl/vcf_genotype_alt_allele_counter.sv
// Genotype alternate-allele counter for tab-separated variant records.
// The closing byte of a sample field is accepted into the input register, then its
// result goes into the result register, where it stays until it is taken.
// Throughput: one byte per cycle while results are taken; a closing byte that
// emits a result waits in the input register while an untaken result is held.
// Reset (arst_n low) clears the line state and loads miss code 3, num_samples 1.
module vcf_genotype_alt_allele_counter (
	input  logic                clk,
	input  logic                arst_n,
	vgac_in_if.sink             in_ch,
	vgac_out_if.source          out_ch,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  vgac_pkg::cfg_data_t cfg_wdata
);
	import vgac_pkg::*;

	// configuration
	count_t     miss_code_q;
	field_num_t num_samples_q;

	// input register
	logic  valid_s1;
	byte_t char_s1;
	logic  end_s1;

	// line state
	field_num_t field_number_q;
	count_t     running_count_q;
	logic       at_field_start_q;
	logic       field_missing_q;
	logic       past_colon_q;

	// result register
	logic        out_valid_s2;
	sample_idx_t idx_s2;
	count_t      cnt_s2;
	logic        last_s2;

	logic       is_tab;
	logic       closes;
	logic       missing_nx;
	logic       colon_nx;
	count_t     count_nx;
	field_num_t g_s1;
	logic       emit_s1;
	logic       out_free;
	logic       s1_go;

	always_comb begin
		is_tab     = (char_s1 == CHAR_TAB);
		closes     = is_tab || end_s1;
		missing_nx = field_missing_q;
		colon_nx   = past_colon_q;
		count_nx   = running_count_q;
		if (!is_tab) begin
			if (at_field_start_q && char_s1 == CHAR_DOT) begin
				missing_nx = 1'b1;
			end
			if (!missing_nx && !past_colon_q) begin
				if (char_s1 == CHAR_ONE) begin
					if (running_count_q != COUNT_MAX) begin
						count_nx = running_count_q + count_t'(1);
					end
				end else if (char_s1 == CHAR_COLON) begin
					colon_nx = 1'b1;
				end
			end
		end
		g_s1    = field_number_q - SKIP_FIELD_NUM;
		emit_s1 = closes && (field_number_q >= SKIP_FIELD_NUM)
			&& (g_s1 < num_samples_q) && (g_s1 < SAMPLE_LIMIT);
	end

	assign out_free    = !out_valid_s2 || out_ch.ready;
	assign s1_go       = valid_s1 && (!emit_s1 || out_free);
	assign in_ch.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_code_q   <= MISSING_RESET;
			num_samples_q <= SAMPLES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MISS_CODE:   miss_code_q   <= cfg_wdata[7:0];
				REG_NUM_SAMPLES: num_samples_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1 <= in_ch.char_byte;
			end_s1  <= in_ch.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_number_q   <= '0;
			running_count_q  <= '0;
			at_field_start_q <= 1'b1;
			field_missing_q  <= 1'b0;
			past_colon_q     <= 1'b0;
		end else if (s1_go) begin
			if (closes) begin
				running_count_q  <= '0;
				at_field_start_q <= 1'b1;
				field_missing_q  <= 1'b0;
				past_colon_q     <= 1'b0;
				if (end_s1) begin
					field_number_q <= '0;
				end else if (field_number_q != FIELD_NUM_MAX) begin
					field_number_q <= field_number_q + field_num_t'(1);
				end
			end else begin
				running_count_q  <= count_nx;
				at_field_start_q <= 1'b0;
				field_missing_q  <= missing_nx;
				past_colon_q     <= colon_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= s1_go && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) begin
			idx_s2  <= g_s1[15:0];
			cnt_s2  <= missing_nx ? miss_code_q : count_nx;
			last_s2 <= end_s1;
		end
	end

	assign out_ch.valid        = out_valid_s2;
	assign out_ch.sample_index = idx_s2;
	assign out_ch.alt_count    = cnt_s2;
	assign out_ch.last_of_line = last_s2;

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && end_s1 |=> field_number_q == '0 && at_field_start_q
			&& running_count_q == '0)
		else $error("line state not cleared at line end");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && emit_s1 |=> out_valid_s2 && last_s2 == $past(end_s1))
		else $error("emitted result not in result register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(char_s1) && $stable(end_s1))
		else $error("stalled byte lost from input register");

endmodule
